>>> rtl/core/mhd_pkg.sv
// mhd_pkg: shared types, codes and the key symbol classifier of the
// modifier hotkey detector
// no dependencies
package mhd_pkg;

    localparam int KEY_CODES_DEF = 256;
    localparam int KEY_CODE_W    = 8;
    localparam int KEY_SYM_W     = 32;
    localparam int CLS_W         = 4;
    localparam int ACT_W         = 2;
    localparam int ST_W          = 3;

    // class bits
    localparam logic [CLS_W-1:0] CLS_NONE  = 4'b0000;
    localparam logic [CLS_W-1:0] CLS_CTRL  = 4'b0001;
    localparam logic [CLS_W-1:0] CLS_SHIFT = 4'b0010;
    localparam logic [CLS_W-1:0] CLS_ALT   = 4'b0100;
    localparam logic [CLS_W-1:0] CLS_SUPER = 4'b1000;

    // detector states
    localparam logic [ST_W-1:0] ST_IDLE     = 3'd0;
    localparam logic [ST_W-1:0] ST_ARMING   = 3'd1;
    localparam logic [ST_W-1:0] ST_ARMED    = 3'd2;
    localparam logic [ST_W-1:0] ST_REARMING = 3'd3;
    localparam logic [ST_W-1:0] ST_FIRING   = 3'd4;
    localparam logic [ST_W-1:0] ST_WEDGED   = 3'd5;

    // actions
    localparam logic [ACT_W-1:0] ACT_NORMAL = 2'd0;
    localparam logic [ACT_W-1:0] ACT_HOTKEY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_IGNORE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_UNARM  = 2'd3;

    // event kinds
    localparam logic OP_PRESS   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // modifier symbols
    localparam logic [KEY_SYM_W-1:0] SYM_SHIFT_L   = 32'h0000_FFE1;
    localparam logic [KEY_SYM_W-1:0] SYM_SHIFT_R   = 32'h0000_FFE2;
    localparam logic [KEY_SYM_W-1:0] SYM_CTRL_L    = 32'h0000_FFE3;
    localparam logic [KEY_SYM_W-1:0] SYM_CTRL_R    = 32'h0000_FFE4;
    localparam logic [KEY_SYM_W-1:0] SYM_ALT_L     = 32'h0000_FFE9;
    localparam logic [KEY_SYM_W-1:0] SYM_ALT_R     = 32'h0000_FFEA;
    localparam logic [KEY_SYM_W-1:0] SYM_SUPER_L   = 32'h0000_FFEB;
    localparam logic [KEY_SYM_W-1:0] SYM_SUPER_R   = 32'h0000_FFEC;
    localparam logic [KEY_SYM_W-1:0] SYM_HYPER_L   = 32'h0000_FFED;
    localparam logic [KEY_SYM_W-1:0] SYM_HYPER_R   = 32'h0000_FFEE;

    // one entry of the per-key table
    typedef struct packed {
        logic             fired;
        logic             held;
        logic [CLS_W-1:0] cls;
    } t_key_word;

    // hyper folds into super
    function automatic logic [CLS_W-1:0] class_of(input logic [KEY_SYM_W-1:0] sym);
        logic [CLS_W-1:0] c;
        case (sym)
            SYM_CTRL_L, SYM_CTRL_R:   c = CLS_CTRL;
            SYM_SHIFT_L, SYM_SHIFT_R: c = CLS_SHIFT;
            SYM_ALT_L, SYM_ALT_R:     c = CLS_ALT;
            SYM_SUPER_L, SYM_SUPER_R,
            SYM_HYPER_L, SYM_HYPER_R: c = CLS_SUPER;
            default:                  c = CLS_NONE;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/mhd_key_index.sv
// mhd_key_index: folds a key code onto the table depth (code modulo depth)
// depends on mhd_pkg
module mhd_key_index #(
    parameter int KEY_CODES = mhd_pkg::KEY_CODES_DEF,
    parameter int IW        = $clog2(KEY_CODES)
) (
    input  logic [mhd_pkg::KEY_CODE_W-1:0] i_key_code,
    output logic [IW-1:0]                  o_idx
);
    import mhd_pkg::*;

    localparam int NCODES = 1 << KEY_CODE_W;

    // constant wrap table, one entry per possible code
    logic [IW-1:0] wrap_tbl [NCODES];

    for (genvar j = 0; j < NCODES; j++) begin : g_tbl
        assign wrap_tbl[j] = IW'(j % KEY_CODES);
    end

    assign o_idx = wrap_tbl[i_key_code];

endmodule

>>> rtl/core/mhd_key_table.sv
// mhd_key_table: per-key memory (held, fired, class) with clearing pass
// and write-to-read forwarding; depends on mhd_pkg
module mhd_key_table #(
    parameter int KEY_CODES = mhd_pkg::KEY_CODES_DEF,
    parameter int IW        = $clog2(KEY_CODES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    output logic               o_clearing,
    input  logic               i_rd_en,
    input  logic [IW-1:0]      i_rd_idx,
    output mhd_pkg::t_key_word o_rd_word,
    input  logic               i_wr_en,
    input  mhd_pkg::t_key_word i_wr_word
);
    import mhd_pkg::*;

    t_key_word mem [KEY_CODES];

    logic          r_clearing;
    logic [IW-1:0] r_clr_idx;
    logic [IW-1:0] r_rd_idx;
    t_key_word     r_rd_word;
    logic          r_last_valid;
    logic [IW-1:0] r_last_idx;
    t_key_word     r_last_word;

    logic          we;
    logic [IW-1:0] wa;
    t_key_word     wd;

    always_comb begin
        if (r_clearing) begin
            we = 1'b1;
            wa = r_clr_idx;
            wd = '0;
        end else begin
            we = i_wr_en;
            wa = r_rd_idx;
            wd = i_wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (i_rd_en) begin
            r_rd_word <= mem[i_rd_idx];
            r_rd_idx  <= i_rd_idx;
        end
        if (i_wr_en) begin
            r_last_idx  <= r_rd_idx;
            r_last_word <= i_wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_clearing   <= 1'b1;
            r_clr_idx    <= '0;
            r_last_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == IW'(KEY_CODES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_wr_en && !r_clearing) begin
                r_last_valid <= 1'b1;
            end
        end
    end

    // a write at the same edge as the read is not in the read data yet
    assign o_rd_word  = (r_last_valid && r_last_idx == r_rd_idx) ? r_last_word : r_rd_word;
    assign o_clearing = r_clearing;

endmodule

>>> rtl/core/mhd_fsm.sv
// mhd_fsm: per-class held counts, held total and the detector state machine;
// decides the action and the new table entry; depends on mhd_pkg
module mhd_fsm #(
    parameter int KEY_CODES = mhd_pkg::KEY_CODES_DEF,
    parameter int CW        = $clog2(KEY_CODES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_fire,
    input  logic                          i_op,
    input  logic [mhd_pkg::CLS_W-1:0]     i_cls,
    input  logic [mhd_pkg::CLS_W-1:0]     i_mask,
    input  mhd_pkg::t_key_word            i_word,
    output mhd_pkg::t_key_word            o_word,
    output logic [mhd_pkg::ACT_W-1:0]     o_action
);
    import mhd_pkg::*;

    logic [ST_W-1:0] r_state, n_state;
    logic [CW-1:0]   r_cnt [CLS_W];
    logic [CW-1:0]   n_cnt [CLS_W];
    logic [CW-1:0]   r_total, n_total;

    logic             is_press;
    logic [CLS_W-1:0] pm;
    logic             in_combo;
    logic [ST_W-1:0]  st;

    always_comb begin
        is_press = (i_op == OP_PRESS);
        for (int b = 0; b < CLS_W; b++) begin
            n_cnt[b] = r_cnt[b];
            if (i_word.held && i_word.cls[b] && r_cnt[b] != '0) begin
                n_cnt[b] = n_cnt[b] - 1'b1;
            end
            if (is_press && i_cls[b]) begin
                n_cnt[b] = n_cnt[b] + 1'b1;
            end
            pm[b] = (n_cnt[b] != '0);
        end

        n_total = r_total;
        if (is_press && !i_word.held) begin
            n_total = r_total + 1'b1;
        end else if (!is_press && i_word.held && r_total != '0) begin
            n_total = r_total - 1'b1;
        end

        in_combo = (i_cls != CLS_NONE) && ((i_cls & ~i_mask) == CLS_NONE);
        n_state  = r_state;
        o_action = ACT_NORMAL;
        st       = r_state;

        if (is_press) begin
            o_word.fired = i_word.fired;
            o_word.held  = 1'b1;
            o_word.cls   = i_cls;
            if (i_mask != CLS_NONE) begin
                case (r_state)
                    ST_IDLE, ST_ARMING, ST_REARMING: begin
                        if (pm == i_mask) begin
                            st = ST_ARMED;
                        end
                        if (in_combo) begin
                            if (st == ST_IDLE) begin
                                st = ST_ARMING;
                            end
                        end else begin
                            st = ST_WEDGED;
                        end
                        n_state = st;
                    end
                    ST_ARMED: begin
                        if (!in_combo) begin
                            if (i_cls != CLS_NONE) begin
                                n_state = ST_WEDGED;
                            end else begin
                                n_state      = ST_FIRING;
                                o_word.fired = 1'b1;
                                o_action     = ACT_HOTKEY;
                            end
                        end
                    end
                    ST_FIRING: begin
                        if (i_cls != CLS_NONE) begin
                            o_action = ACT_IGNORE;
                        end else begin
                            o_word.fired = 1'b1;
                            o_action     = ACT_HOTKEY;
                        end
                    end
                    default: begin
                        o_action = ACT_NORMAL;
                    end
                endcase
            end
        end else begin
            o_word.fired = 1'b0;
            o_word.held  = 1'b0;
            o_word.cls   = i_word.cls;
            case (r_state)
                ST_ARMED: begin
                    if (n_total == '0) begin
                        o_action = ACT_UNARM;
                    end else if (pm != i_mask) begin
                        n_state = ST_REARMING;
                    end
                end
                ST_REARMING: begin
                    if (n_total == '0) begin
                        o_action = ACT_UNARM;
                    end
                end
                ST_FIRING: begin
                    o_action = i_word.fired ? ACT_HOTKEY : ACT_IGNORE;
                end
                default: begin
                    o_action = ACT_NORMAL;
                end
            endcase
            if (n_total == '0) begin
                n_state = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state <= ST_IDLE;
            r_total <= '0;
            for (int b = 0; b < CLS_W; b++) begin
                r_cnt[b] <= '0;
            end
        end else if (i_fire) begin
            r_state <= n_state;
            r_total <= n_total;
            for (int b = 0; b < CLS_W; b++) begin
                r_cnt[b] <= n_cnt[b];
            end
        end
    end

endmodule

>>> rtl/core/modifier_hotkey_detector.sv
// modifier_hotkey_detector: top level, stream ports, combo register and the
// three-stage item pipeline; depends on mhd_pkg, mhd_key_index,
// mhd_key_table and mhd_fsm
//
//  channel  dir  handshake                fields
//  s        in   i_s_tvalid / o_s_tready  tuser[0] operation, tdata key_code, key_symbol
//  m        out  o_m_tvalid / i_m_tready  tdata[1:0] action
//  cfg      in   i_cfg_valid / o_cfg_ready data[3:0] combo_mask
//
// one item per cycle sustained unless a result stalls or a clearing pass runs; an
// item's result is presented after the input, table read and result registers
// the per-key table has one read and one write port; a write made at the
// same edge as the next read is forwarded from a holding register
// after reset and after every combo_mask write a clearing pass runs over the
// whole table, during which no item is accepted
// a stalled result freezes the whole pipeline; outside the clearing pass
// tready falls only then
module modifier_hotkey_detector #(
    parameter int KEY_CODES = mhd_pkg::KEY_CODES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [39:0]                     i_s_tdata,   // key_code[7:0], key_symbol[39:8]
    input  logic [0:0]                      i_s_tuser,   // operation[0]
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [7:0]                      o_m_tdata,   // action[1:0], zeros above
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mhd_pkg::CLS_W-1:0]       i_cfg_data
);
    import mhd_pkg::*;

    localparam int IW = $clog2(KEY_CODES);

    // combo register
    logic [CLS_W-1:0] r_mask;
    logic             cfg_wr;

    // pipeline control
    logic en;
    logic s_accept;
    logic fire;
    logic clearing;

    // stage 1: input register
    logic                  r_s1_valid;
    logic                  r_s1_op;
    logic [KEY_CODE_W-1:0] r_s1_code;
    logic [KEY_SYM_W-1:0]  r_s1_sym;
    logic [IW-1:0]         s1_idx;

    // stage 2: table data available
    logic             r_s2_valid;
    logic             r_s2_op;
    logic [CLS_W-1:0] r_s2_cls;
    t_key_word        s2_word;
    t_key_word        s2_new_word;
    logic [ACT_W-1:0] s2_action;

    // result register
    logic             r_out_valid;
    logic [ACT_W-1:0] r_out_act;

    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en && !clearing;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign fire       = en && r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (cfg_wr) begin
            r_mask <= i_cfg_data;
        end
    end

    // control of the item pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= s_accept;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_op   <= i_s_tuser[0];
            r_s1_code <= i_s_tdata[7:0];
            r_s1_sym  <= i_s_tdata[39:8];
        end
        if (en) begin
            r_s2_op  <= r_s1_op;
            r_s2_cls <= class_of(r_s1_sym);
        end
        if (fire) begin
            r_out_act <= s2_action;
        end
    end

    mhd_key_index #(
        .KEY_CODES (KEY_CODES),
        .IW        (IW)
    ) u_index (
        .i_key_code (r_s1_code),
        .o_idx      (s1_idx)
    );

    mhd_key_table #(
        .KEY_CODES (KEY_CODES),
        .IW        (IW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cfg_wr),
        .o_clearing (clearing),
        .i_rd_en    (en),
        .i_rd_idx   (s1_idx),
        .o_rd_word  (s2_word),
        .i_wr_en    (fire),
        .i_wr_word  (s2_new_word)
    );

    mhd_fsm #(
        .KEY_CODES (KEY_CODES)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cfg_wr),
        .i_fire   (fire),
        .i_op     (r_s2_op),
        .i_cls    (r_s2_cls),
        .i_mask   (r_mask),
        .i_word   (s2_word),
        .o_word   (s2_new_word),
        .o_action (s2_action)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(8 - ACT_W){1'b0}}, r_out_act};

`ifndef NO_ASSERTIONS
    // an item in the decide stage is not lost while the result side stalls
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !en) |=> r_s2_valid)
        else $error("decide stage dropped an item under stall");

    // every decided item shows up as a result in the next cycle
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_m_tvalid)
        else $error("decided item produced no result");

    // reset leaves no item in flight
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && !r_s1_valid && !r_s2_valid))
        else $error("pipeline not empty after reset");

    // nothing is accepted right after a combo_mask write starts the clearing pass
    a_no_accept_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(cfg_wr) |-> !s_accept)
        else $error("item accepted during clearing pass");
`endif

endmodule
